>>> rtl/core/assert_macros.svh
// Assertion macros for the checker file of the framer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define RPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define RPF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/core/rpf_pkg.sv
// Types and constants of the radio packet to host framer.
`default_nettype none

package rpf_pkg;

    // Frame and address constants.
    localparam logic [7:0] SYNC_FIRST         = 8'hA5;
    localparam logic [7:0] SYNC_SECOND        = 8'h5A;
    localparam logic [7:0] BROADCAST_ADDR     = 8'hFF;
    localparam logic [7:0] STATION_ADDR_RESET = 8'hBB;

    // Register index of the configuration space.
    localparam logic REG_STATION_ADDR = 1'b0;

    // Byte positions within a received packet; the last one saturates.
    localparam logic [2:0] POS_RECIPIENT = 3'd0;
    localparam logic [2:0] POS_ID        = 3'd2;
    localparam logic [2:0] POS_LENGTH    = 3'd3;
    localparam logic [2:0] POS_PAYLOAD   = 3'd4;

    // Byte indexes within a host frame.
    localparam logic [8:0] FRM_SYNC0     = 9'd0;
    localparam logic [8:0] FRM_SYNC1     = 9'd1;
    localparam logic [8:0] FRM_ID        = 9'd2;
    localparam logic [8:0] FRM_COUNT     = 9'd3;
    localparam logic [8:0] FRM_RSSI_LO   = 9'd4;
    localparam logic [8:0] FRM_RSSI_HI   = 9'd5;
    localparam logic [8:0] FRM_SNR       = 9'd6;
    localparam logic [8:0] FRM_HDR_BYTES = 9'd7;

    // Last lane of a chunk.
    localparam logic [2:0] LANE_LAST = 3'd7;
    localparam logic [3:0] CHUNK_FULL = 4'd8;

    typedef struct packed {
        logic [7:0]        rx_byte;
        logic              end_of_packet;
        logic signed [15:0] rssi;
        logic signed [7:0] snr_quarter_db;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte_0;
        logic [7:0] out_byte_1;
        logic [7:0] out_byte_2;
        logic [7:0] out_byte_3;
        logic [7:0] out_byte_4;
        logic [7:0] out_byte_5;
        logic [7:0] out_byte_6;
        logic [7:0] out_byte_7;
        logic [3:0] byte_count;
        logic       last_chunk;
    } t_out_item;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/core/radio_packet_to_host_framer_top.sv
// Radio packet to host framer: packet parsing, payload store and chunked frame output.
`default_nettype none

// The block takes one radio byte per cycle while it is idle. When the final byte of a
// packet for this station arrives, the input stalls while the host frame is read out
// of the payload RAM one byte per cycle through its single port, with a pause at each
// handoff between consecutive chunks and while the host stalls: a payload of n bytes
// gives a frame of n + 8 bytes in ceil((n + 8) / 8) chunks. Other packet ends do not
// stall the input. The station address (register 0, byte address 0) resets to 0xBB.
// The payload RAM has no clearing pass; only entries written in the current packet
// are read.
module radio_packet_to_host_framer_top import rpf_pkg::*; #(
    parameter int PAYLOAD_DEPTH = 256
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    // Input item channel.
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    // Result item channel.
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data,
    // Configuration port.
    input  wire logic      psel,
    input  wire logic      penable,
    input  wire logic      pwrite,
    input  wire logic [2:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam logic [8:0] DEPTH_LIMIT = 9'(PAYLOAD_DEPTH);

    // Configuration and packet state.
    logic [7:0] r_station_addr;
    logic [2:0] r_pos;
    logic [7:0] r_recipient;
    logic [7:0] r_id;
    logic [7:0] r_decl;
    logic [7:0] r_count;
    logic [7:0] r_sum;

    // Frame being drained.
    logic [7:0] r_f_id;
    logic [7:0] r_f_n;
    logic [7:0] r_f_rlo;
    logic [7:0] r_f_rhi;
    logic [7:0] r_f_snr;
    logic [7:0] r_f_chk;
    logic [8:0] r_f_last;

    t_state r_state;
    t_state n_state;

    // Read issue and byte select stages.
    logic [8:0] r_k;
    logic       r_s2_valid;
    logic [8:0] r_s2_k;

    // Chunk assembly and output register.
    logic [7:0] r_asm [8];
    logic       r_asm_full;
    logic [3:0] r_asm_cnt;
    logic       r_asm_last;
    logic       r_out_valid;
    t_out_item  r_out;

    logic       in_acc;
    logic       out_acc;
    logic       store;
    logic [7:0] cnt_new;
    logic [7:0] sum_new;
    logic [7:0] chk_new;
    logic       qualify;
    logic       xfer;
    logic       s2_eoc;
    logic       issue;
    logic [8:0] ram_off;
    logic [AW-1:0] ram_addr;
    logic [7:0] ram_q;
    logic [7:0] s2_byte;
    logic [2:0] s2_lane;
    t_out_item  asm_item;
    logic       cfg_wr;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STATION_ADDR);
    assign prdata = (psel && (paddr[2] == REG_STATION_ADDR)) ? {24'd0, r_station_addr}
                                                             : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_addr <= STATION_ADDR_RESET;
        end else if (cfg_wr) begin
            r_station_addr <= pwdata[7:0];
        end
    end

    // Packet parsing for the accepted item.
    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_out_valid && !i_out_stall;
    assign store   = (r_pos == POS_PAYLOAD) && ({1'b0, r_count} < {1'b0, r_decl})
                     && ({1'b0, r_count} < DEPTH_LIMIT);
    assign cnt_new = store ? r_count + 8'd1 : r_count;
    assign sum_new = store ? r_sum + i_in_data.rx_byte : r_sum;
    assign chk_new = r_id + cnt_new + i_in_data.rssi[7:0] + i_in_data.rssi[15:8]
                     + i_in_data.snr_quarter_db[7:0] + sum_new;
    assign qualify = in_acc && i_in_data.end_of_packet && (r_pos >= POS_LENGTH)
                     && ((r_recipient == r_station_addr) || (r_recipient == BROADCAST_ADDR));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_RECIPIENT;
            r_recipient <= 8'd0;
            r_id        <= 8'd0;
            r_decl      <= 8'd0;
            r_count     <= 8'd0;
            r_sum       <= 8'd0;
        end else if (in_acc) begin
            if (i_in_data.end_of_packet) begin
                r_pos       <= POS_RECIPIENT;
                r_recipient <= 8'd0;
                r_id        <= 8'd0;
                r_decl      <= 8'd0;
                r_count     <= 8'd0;
                r_sum       <= 8'd0;
            end else begin
                if (r_pos != POS_PAYLOAD) begin
                    r_pos <= r_pos + 3'd1;
                end
                if (r_pos == POS_RECIPIENT) begin
                    r_recipient <= i_in_data.rx_byte;
                end
                if (r_pos == POS_ID) begin
                    r_id <= i_in_data.rx_byte;
                end
                if (r_pos == POS_LENGTH) begin
                    r_decl <= i_in_data.rx_byte;
                end
                r_count <= cnt_new;
                r_sum   <= sum_new;
            end
        end
    end

    // Frame header latched at the end of a packet for this station.
    always_ff @(posedge i_clk) begin
        if (qualify) begin
            r_f_id   <= r_id;
            r_f_n    <= cnt_new;
            r_f_rlo  <= i_in_data.rssi[7:0];
            r_f_rhi  <= i_in_data.rssi[15:8];
            r_f_snr  <= i_in_data.snr_quarter_db[7:0];
            r_f_chk  <= chk_new;
            r_f_last <= {1'b0, cnt_new} + FRM_HDR_BYTES;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (qualify) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (issue && (r_k == r_f_last)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // State outputs: input stall and read issue. A read pauses after the last
    // lane of a chunk and while a finished chunk cannot move on.
    assign xfer   = r_asm_full && (!r_out_valid || out_acc);
    assign s2_eoc = (r_s2_k[2:0] == LANE_LAST) || (r_s2_k == r_f_last);

    always_comb begin
        o_in_stall = 1'b1;
        issue      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
            end
            S_EMIT: begin
                issue = !(r_s2_valid && s2_eoc) && (!r_asm_full || xfer);
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Payload RAM: written while parsing, read while draining.
    assign ram_off  = r_k - FRM_HDR_BYTES;
    assign ram_addr = store ? r_count[AW-1:0] : ram_off[AW-1:0];

    rpf_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && store),
        .i_re    (issue),
        .i_addr  (ram_addr),
        .i_wdata (i_in_data.rx_byte),
        .o_rdata (ram_q)
    );

    // Frame index counter and select stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k        <= 9'd0;
            r_s2_valid <= 1'b0;
        end else begin
            if (qualify) begin
                r_k <= 9'd0;
            end else if (issue) begin
                r_k <= r_k + 9'd1;
            end
            r_s2_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s2_k <= r_k;
        end
    end

    always_comb begin
        case (r_s2_k)
            FRM_SYNC0:   s2_byte = SYNC_FIRST;
            FRM_SYNC1:   s2_byte = SYNC_SECOND;
            FRM_ID:      s2_byte = r_f_id;
            FRM_COUNT:   s2_byte = r_f_n;
            FRM_RSSI_LO: s2_byte = r_f_rlo;
            FRM_RSSI_HI: s2_byte = r_f_rhi;
            FRM_SNR:     s2_byte = r_f_snr;
            default:     s2_byte = (r_s2_k == r_f_last) ? r_f_chk : ram_q;
        endcase
    end

    assign s2_lane = r_s2_k[2:0];

    // Chunk assembly; lanes are cleared on handoff so unused lanes read zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_asm[i] <= 8'd0;
            end
            r_asm_full <= 1'b0;
            r_asm_cnt  <= 4'd0;
            r_asm_last <= 1'b0;
        end else if (xfer) begin
            for (int i = 0; i < 8; i++) begin
                r_asm[i] <= 8'd0;
            end
            r_asm_full <= 1'b0;
        end else if (r_s2_valid) begin
            r_asm[s2_lane] <= s2_byte;
            if (s2_eoc) begin
                r_asm_full <= 1'b1;
                r_asm_cnt  <= {1'b0, s2_lane} + 4'd1;
                r_asm_last <= (r_s2_k == r_f_last);
            end
        end
    end

    always_comb begin
        asm_item.out_byte_0 = r_asm[0];
        asm_item.out_byte_1 = r_asm[1];
        asm_item.out_byte_2 = r_asm[2];
        asm_item.out_byte_3 = r_asm[3];
        asm_item.out_byte_4 = r_asm[4];
        asm_item.out_byte_5 = r_asm[5];
        asm_item.out_byte_6 = r_asm[6];
        asm_item.out_byte_7 = r_asm[7];
        asm_item.byte_count = r_asm_cnt;
        asm_item.last_chunk = r_asm_last;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (xfer) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_out <= asm_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> rtl/core/rpf_ram.sv
// Generic single-port RAM with a registered read.
`default_nettype none

module rpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic                                  i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port share one address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/rpf_checker.sv
// Port-level checker for the framer and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module rpf_checker import rpf_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data
);

    // A stalled chunk stays offered.
    `RPF_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "chunk dropped while stalled")

    // Every chunk carries between one and eight bytes.
    `RPF_ASSERT(a_count_range, o_out_valid |-> (o_out_data.byte_count != 4'd0) && (o_out_data.byte_count <= CHUNK_FULL), "chunk byte count out of range")

    // Only the chunk with the checksum may be short.
    `RPF_ASSERT(a_full_chunk, o_out_valid && !o_out_data.last_chunk |-> o_out_data.byte_count == CHUNK_FULL, "short chunk before the last")

    // The top lane of a short chunk is zero.
    `RPF_ASSERT(a_pad_zero, o_out_valid && (o_out_data.byte_count != CHUNK_FULL) |-> o_out_data.out_byte_7 == 8'd0, "unused lane not zero")

    // Reset empties the output register.
    `RPF_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind radio_packet_to_host_framer_top rpf_checker u_rpf_checker (.*);

`default_nettype wire
